FILE: rtl/core/asdc_pkg.sv
// ----------------------------------------------------------------------------
// asdc_pkg
// Shared types, widths and constants of the silhouette depth/contour block.
// ----------------------------------------------------------------------------
package asdc_pkg;

   // Default frame limits
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // Configuration register widths and indexes
   localparam int THR_W   = 8;
   localparam int SIZE_W  = 11;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;
   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_WIDTH     = 2'd1;
   localparam logic [1:0] REG_HEIGHT    = 2'd2;

   // Effective size: holds up to 8191
   localparam int DIM_W = 13;
   localparam int DX_W  = DIM_W + 2;

   // Item field widths
   localparam int CHAN_W    = 8;
   localparam int OUT_CRD_W = 10;
   localparam int DEPTH_W   = 8;

   // Depth arithmetic (Q16 luma weights pre-scaled by 0.7)
   localparam int LUMA_W  = 24;
   localparam int W_RED   = 13717;
   localparam int W_GREEN = 26929;
   localparam int W_BLUE  = 5230;
   localparam int SQ_W    = 26;
   localparam int FRAC_W  = 16;
   localparam int RAD_W   = SQ_W + 2 * FRAC_W;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int REM_W   = ROOT_W + 3;
   localparam int DQ_W    = 19;
   localparam int DF_W    = DQ_W + 2;
   localparam int TOT_W   = 32;
   localparam int DEPTH_K = 153;
   localparam int ONE_Q16 = 65536;
   localparam int TOT_SHIFT = 17;

   // Iterative unit step counts
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = ROOT_W;
   localparam int ITER_W     = $clog2(ROOT_W + 1);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } req_type;

   typedef struct packed {
      logic [OUT_CRD_W-1:0] col;
      logic [OUT_CRD_W-1:0] row;
      logic [DEPTH_W-1:0]   depth;
      logic                 foreground;
      logic                 contour;
      logic                 end_of_run;
      logic                 end_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [THR_W-1:0] threshold;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic rd_cur;
      logic rd_next;
      logic sq_init;
      logic sq_step;
      logic dv_init;
      logic dv_step;
      logic finish;
      logic emit_up;
      logic emit_own;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic has_prev;
      logic last_row;
      logic out_free;
   } sts_type;

endpackage

FILE: rtl/core/asdc_stream_if.sv
// ----------------------------------------------------------------------------
// asdc_stream_if
// Valid/ready stream channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface asdc_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/alpha_silhouette_depth_contour.sv
// Sequence: after acceptance come two line store reads, 29 square root steps and 29 divide
// steps, then the depth is finished and the results of the item are presented.
// A new item is accepted only after the previous one, with its zero, one or two results, has
// been committed; the emits wait while the sink holds the output.
// Reset: synchronous, active high; counters, state and CSRs return to defaults,
// the line store is not cleared.
// ----------------------------------------------------------------------------
// alpha_silhouette_depth_contour
// RGBA raster pixels in, per-pixel foreground, pseudo-depth and contour out,
// one row behind through a line store; the last row also emits its own results.
// ----------------------------------------------------------------------------
module alpha_silhouette_depth_contour #(
   parameter int MAX_WIDTH  = asdc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = asdc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                        clock,
   input  logic                        reset,
   asdc_stream_if.sink                 req,
   asdc_stream_if.source               rsp,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [asdc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [asdc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [asdc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import asdc_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;
   logic    in_ready;

   asdc_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   asdc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (in_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   asdc_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_data   (req.data),
      .cmd       (cmd),
      .sts       (sts),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp.data)
   );

   assign req.ready = in_ready;

endmodule

FILE: rtl/core/asdc_csr.sv
// ----------------------------------------------------------------------------
// asdc_csr
// APB register file: threshold and frame size, with clamped size outputs.
// ----------------------------------------------------------------------------
module asdc_csr #(
   parameter int MAX_WIDTH  = asdc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = asdc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [asdc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [asdc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [asdc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready,
   output asdc_pkg::cfg_type           cfg
);
   import asdc_pkg::*;

   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [SIZE_W-1:0] wid_ff, wid_in;
   logic [SIZE_W-1:0] hgt_ff, hgt_in;
   logic              wr_en;
   logic [1:0]        idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[3:2];

   // Register writes
   always_comb begin
      thr_in = thr_ff;
      wid_in = wid_ff;
      hgt_in = hgt_ff;
      if (wr_en) begin
         case (idx)
            REG_THRESHOLD: thr_in = csr_pwdata[THR_W-1:0];
            REG_WIDTH:     wid_in = csr_pwdata[SIZE_W-1:0];
            REG_HEIGHT:    hgt_in = csr_pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
         wid_ff <= SIZE_W'(DEF_MAX_WIDTH);
         hgt_ff <= SIZE_W'(DEF_MAX_HEIGHT);
      end else begin
         thr_ff <= thr_in;
         wid_ff <= wid_in;
         hgt_ff <= hgt_in;
      end
   end

   // Read back
   always_comb begin
      case (idx)
         REG_THRESHOLD: csr_prdata = CSR_DW'(thr_ff);
         REG_WIDTH:     csr_prdata = CSR_DW'(wid_ff);
         REG_HEIGHT:    csr_prdata = CSR_DW'(hgt_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Zero reads as one, oversize saturates
   always_comb begin
      cfg.threshold = thr_ff;
      if (wid_ff == '0)
         cfg.width = DIM_W'(1);
      else if (DIM_W'(wid_ff) > DIM_W'(MAX_WIDTH))
         cfg.width = DIM_W'(MAX_WIDTH);
      else
         cfg.width = DIM_W'(wid_ff);
      if (hgt_ff == '0)
         cfg.height = DIM_W'(1);
      else if (DIM_W'(hgt_ff) > DIM_W'(MAX_HEIGHT))
         cfg.height = DIM_W'(MAX_HEIGHT);
      else
         cfg.height = DIM_W'(hgt_ff);
   end

endmodule

FILE: rtl/core/asdc_ctrl.sv
// ----------------------------------------------------------------------------
// asdc_ctrl
// Sequencer: line store reads, square root and divide iterations, emits.
// ----------------------------------------------------------------------------
module asdc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  asdc_pkg::sts_type sts,
   output asdc_pkg::cmd_type cmd
);
   import asdc_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_RD_CUR   = 4'd1;
   localparam logic [3:0] S_RD_NEXT  = 4'd2;
   localparam logic [3:0] S_SQ_INIT  = 4'd3;
   localparam logic [3:0] S_SQRT     = 4'd4;
   localparam logic [3:0] S_DV_INIT  = 4'd5;
   localparam logic [3:0] S_DIV      = 4'd6;
   localparam logic [3:0] S_FINISH   = 4'd7;
   localparam logic [3:0] S_EMIT_UP  = 4'd8;
   localparam logic [3:0] S_EMIT_OWN = 4'd9;
   localparam logic [3:0] S_COMMIT   = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_RD_CUR;
            end
         end
         S_RD_CUR: begin
            cmd.rd_cur = 1'b1;
            state_in   = S_RD_NEXT;
         end
         S_RD_NEXT: begin
            cmd.rd_next = 1'b1;
            state_in    = S_SQ_INIT;
         end
         S_SQ_INIT: begin
            cmd.sq_init = 1'b1;
            iter_in     = '0;
            state_in    = S_SQRT;
         end
         S_SQRT: begin
            cmd.sq_step = 1'b1;
            iter_in     = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(SQRT_STEPS - 1))
               state_in = S_DV_INIT;
         end
         S_DV_INIT: begin
            cmd.dv_init = 1'b1;
            iter_in     = '0;
            state_in    = S_DIV;
         end
         S_DIV: begin
            cmd.dv_step = 1'b1;
            iter_in     = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(DIV_STEPS - 1))
               state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            if (sts.has_prev)
               state_in = S_EMIT_UP;
            else if (sts.last_row)
               state_in = S_EMIT_OWN;
            else
               state_in = S_COMMIT;
         end
         S_EMIT_UP: begin
            if (sts.out_free) begin
               cmd.emit_up = 1'b1;
               state_in    = sts.last_row ? S_EMIT_OWN : S_COMMIT;
            end
         end
         S_EMIT_OWN: begin
            if (sts.out_free) begin
               cmd.emit_own = 1'b1;
               state_in     = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   // Checks
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.emit_up, cmd.emit_own, cmd.commit}))
      else $error("more than one major command");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_up || cmd.emit_own) |-> sts.out_free)
      else $error("emit into a busy output register");
   a_commit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> in_ready)
      else $error("not idle after commit");
   a_iter_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT || state_ff == S_DIV) |-> iter_ff < ITER_W'(SQRT_STEPS))
      else $error("iteration count overrun");

endmodule

FILE: rtl/core/asdc_dpath.sv
// ----------------------------------------------------------------------------
// asdc_dpath
// Coordinates, line store, bit-serial sqrt and divide, depth and output register.
// ----------------------------------------------------------------------------
module asdc_dpath #(
   parameter int MAX_WIDTH  = asdc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = asdc_pkg::DEF_MAX_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  asdc_pkg::cfg_type cfg,
   input  asdc_pkg::req_type in_data,
   input  asdc_pkg::cmd_type cmd,
   output asdc_pkg::sts_type sts,
   output logic              out_valid,
   input  logic              out_ready,
   output asdc_pkg::rsp_type out_data
);
   import asdc_pkg::*;

   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int MW = 2 + DEPTH_W;

   // Frame counters and current item
   logic [XW-1:0]      col_ff, col_in;
   logic [YW-1:0]      row_ff, row_in;
   logic [XW-1:0]      x_ff;
   logic [YW-1:0]      y_ff;
   req_type            pix_ff;
   logic               fg_ff;
   logic [LUMA_W-1:0]  luma_ff;
   logic [DEPTH_W-1:0] dep_ff;

   // Line store and neighbour flags
   logic [MW-1:0]      line_mem [MAX_WIDTH];
   logic [MW-1:0]      mem_q_ff;
   logic [XW-1:0]      rd_addr;
   logic               pfg_ff, tfg_ff, right_ff, left_ff;
   logic [DEPTH_W-1:0] pdep_ff;

   // Iterative units
   logic [RAD_W-1:0]   rad_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [ROOT_W-1:0]  quo_ff;
   logic [DIM_W-1:0]   dvr_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [DIM_W:0]     nx_cmp, ny_cmp;
   logic [DIM_W:0]     ax_cmp, ay_cmp;
   logic [XW-1:0]      ax;
   logic [YW-1:0]      ay;
   logic               edge_pix, cont_up;

   // Normalized coordinates of the arriving item (size may have shrunk)
   always_comb begin
      ax_cmp = (DIM_W+1)'(col_ff);
      ay_cmp = (DIM_W+1)'(row_ff);
      if (ax_cmp >= (DIM_W+1)'(cfg.width)) begin
         ax     = '0;
         ay_cmp = ay_cmp + 1'b1;
      end else begin
         ax = col_ff;
      end
      if (ay_cmp >= (DIM_W+1)'(cfg.height))
         ay = '0;
      else
         ay = YW'(ay_cmp);
   end

   // Counter advance at commit
   always_comb begin
      nx_cmp = (DIM_W+1)'(x_ff) + 1'b1;
      ny_cmp = (DIM_W+1)'(y_ff) + 1'b1;
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.commit) begin
         if (nx_cmp >= (DIM_W+1)'(cfg.width)) begin
            col_in = '0;
            row_in = (ny_cmp >= (DIM_W+1)'(cfg.height)) ? '0 : YW'(ny_cmp);
         end else begin
            col_in = XW'(nx_cmp);
            row_in = y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (cmd.commit)
            left_ff <= pfg_ff;
      end
   end

   assign sts.has_prev = (y_ff != '0);
   assign sts.last_row = ((DIM_W)'(y_ff) == cfg.height - 1'b1);
   assign sts.out_free = !rsp_valid_ff || out_ready;

   // Item capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff   <= ax;
         y_ff   <= ay;
         pix_ff <= in_data;
         fg_ff  <= (in_data.alpha > cfg.threshold);
      end
   end

   // Line store: one port, registered read
   assign rd_addr = cmd.rd_next ? x_ff + 1'b1 : x_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit)
         line_mem[x_ff] <= {fg_ff, pfg_ff, dep_ff};
      else if (cmd.rd_cur || cmd.rd_next)
         mem_q_ff <= line_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_next) begin
         pfg_ff  <= mem_q_ff[MW-1];
         tfg_ff  <= mem_q_ff[MW-2];
         pdep_ff <= mem_q_ff[DEPTH_W-1:0];
      end
      if (cmd.sq_init)
         right_ff <= mem_q_ff[MW-1];
   end

   // Luma and squared distance, then digit-by-digit square root
   logic [DIM_W:0]          x2, y2;
   logic signed [DX_W-1:0]  dx, dy;
   logic signed [2*DX_W-1:0] sqx, sqy;
   logic [SQ_W-1:0]         ssum;
   logic [REM_W-1:0]        r2, trial;

   always_comb begin
      x2   = {DIM_W'(x_ff), 1'b0};
      y2   = {DIM_W'(y_ff), 1'b0};
      dx   = signed'({1'b0, x2}) - signed'({2'b00, cfg.width});
      dy   = signed'({1'b0, y2}) - signed'({2'b00, cfg.height});
      sqx  = dx * dx;
      sqy  = dy * dy;
      ssum = SQ_W'(sqx) + SQ_W'(sqy);
      r2    = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial = REM_W'({root_ff, 2'b01});
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_init) begin
         luma_ff <= LUMA_W'(W_RED * pix_ff.red) + LUMA_W'(W_GREEN * pix_ff.green)
                  + LUMA_W'(W_BLUE * pix_ff.blue);
         rad_ff  <= {ssum, (2*FRAC_W)'(0)};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sq_step) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (r2 >= trial) begin
            rem_ff  <= r2 - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= r2;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   function automatic logic [DIM_W-1:0] sts_max_side();
      return (cfg.width > cfg.height) ? cfg.width : cfg.height;
   endfunction

   // Restoring divide of the root by the larger frame side
   logic [DIM_W:0] dt;
   assign dt = {dvr_ff, quo_ff[ROOT_W-1]};

   always_ff @(posedge clock) begin
      if (cmd.dv_init) begin
         quo_ff <= root_ff;
         dvr_ff <= '0;
      end else if (cmd.dv_step) begin
         if (dt >= (DIM_W+1)'(sts_max_side())) begin
            dvr_ff <= DIM_W'(dt - (DIM_W+1)'(sts_max_side()));
            quo_ff <= {quo_ff[ROOT_W-2:0], 1'b1};
         end else begin
            dvr_ff <= DIM_W'(dt);
            quo_ff <= {quo_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Depth: 2*luma + 153*(1 - dist), truncate and saturate
   logic signed [DF_W-1:0]  diff;
   logic signed [TOT_W-1:0] total;
   logic signed [TOT_W-1:0] shifted;

   always_comb begin
      diff    = signed'(DF_W'(ONE_Q16)) - signed'(DF_W'(quo_ff[DQ_W-1:0]));
      total   = TOT_W'(signed'({1'b0, luma_ff, 1'b0})) + TOT_W'(diff) * TOT_W'(DEPTH_K);
      shifted = total >>> TOT_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (!fg_ff || total <= 0)
            dep_ff <= '0;
         else if (shifted > TOT_W'(255))
            dep_ff <= '1;
         else
            dep_ff <= shifted[DEPTH_W-1:0];
      end
   end

   // Contour of the pixel one row up
   always_comb begin
      edge_pix = (x_ff == '0) || (DIM_W'(x_ff) == cfg.width - 1'b1)
               || (y_ff == YW'(1));
      cont_up  = edge_pix || !tfg_ff || !left_ff || !right_ff || !fg_ff;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.emit_up || cmd.emit_own)
         rsp_valid_ff <= 1'b1;
      else if (out_ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_up) begin
         rsp_ff.col          <= OUT_CRD_W'(x_ff);
         rsp_ff.row          <= OUT_CRD_W'(y_ff - 1'b1);
         rsp_ff.depth        <= pfg_ff ? pdep_ff : '0;
         rsp_ff.foreground   <= pfg_ff;
         rsp_ff.contour      <= pfg_ff & cont_up;
         rsp_ff.end_of_run   <= !sts.last_row;
         rsp_ff.end_of_frame <= 1'b0;
      end else if (cmd.emit_own) begin
         rsp_ff.col          <= OUT_CRD_W'(x_ff);
         rsp_ff.row          <= OUT_CRD_W'(y_ff);
         rsp_ff.depth        <= dep_ff;
         rsp_ff.foreground   <= fg_ff;
         rsp_ff.contour      <= fg_ff;
         rsp_ff.end_of_run   <= 1'b1;
         rsp_ff.end_of_frame <= (DIM_W'(x_ff) == cfg.width - 1'b1);
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the silhouette depth/contour block. RGBA frames stream in with
// random gaps and output stalls, and a behavioral model in this file predicts
// each result: position, foreground flag, pseudo-depth, contour and the end
// markers. Each result is checked field by field against the oldest expected
// result. Frame sizes and the threshold change only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
   import asdc_pkg::*;

   localparam int FRAME_MAX  = 1024;
   localparam int DRAIN_WAIT = 90;
   localparam int CYCLE_CAP  = 2500000;
   localparam logic [CSR_AW-1:0] ADDR_THRESHOLD = CSR_AW'(4 * REG_THRESHOLD);
   localparam logic [CSR_AW-1:0] ADDR_WIDTH     = CSR_AW'(4 * REG_WIDTH);
   localparam logic [CSR_AW-1:0] ADDR_HEIGHT    = CSR_AW'(4 * REG_HEIGHT);

   logic clock = 1'b0;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   asdc_stream_if #(.payload_type(req_type)) pixel_ch ();
   asdc_stream_if #(.payload_type(rsp_type)) result_ch ();

   alpha_silhouette_depth_contour DUT (
      .clock(clock), .reset(reset), .req(pixel_ch), .rsp(result_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   // Model copy of the registers and the raster state
   int unsigned alpha_limit = 0;
   int unsigned width_reg = 1024;
   int unsigned height_reg = 1024;
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;
   bit          fg_line_prev [FRAME_MAX];
   bit          fg_line_two  [FRAME_MAX];
   logic [7:0]  depth_line   [FRAME_MAX];

   rsp_type pending_results[$];
   int      error_count = 0;
   int      pixels_sent = 0;
   bit      src_idle_on = 1'b1;
   bit      sink_idle_on = 1'b1;
   longint  cycle_count = 0;

   function automatic int unsigned eff_size(int unsigned v);
      if (v < 1) return 1;
      return (v > FRAME_MAX) ? FRAME_MAX : v;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root, bitpos;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
         if (v >= root + bitpos) begin
            v -= root + bitpos;
            root = (root >> 1) + bitpos;
         end else begin
            root >>= 1;
         end
         bitpos >>= 2;
      end
      return root;
   endfunction

   // 0.7*luma plus a radial falloff, in units of 2^-17
   function automatic logic [7:0] pseudo_depth(req_type px, int unsigned x,
                                                int unsigned y, int unsigned w,
                                                int unsigned h);
      longint luma, dx, dy, total, dq, span;
      longint unsigned sq;
      luma = 13717 * longint'(px.red) + 26929 * longint'(px.green)
             + 5230 * longint'(px.blue);
      dx = 2 * longint'(x) - longint'(w);
      dy = 2 * longint'(y) - longint'(h);
      sq = longint'(dx * dx + dy * dy);
      span = (w > h) ? longint'(w) : longint'(h);
      dq = longint'(floor_sqrt(sq << 32)) / span;
      total = 2 * luma + 153 * (65536 - dq);
      if (total <= 0) return 8'd0;
      total = total >>> 17;
      return (total > 255) ? 8'd255 : total[7:0];
   endfunction

   function automatic rsp_type make_result(int unsigned x, int unsigned y,
                                           logic [7:0] dep, bit fg, bit cont,
                                           bit eor, bit eof);
      rsp_type r;
      r.col = x[9:0];
      r.row = y[9:0];
      r.depth = fg ? dep : 8'd0;
      r.foreground = fg;
      r.contour = fg & cont;
      r.end_of_run = eor;
      r.end_of_frame = eof;
      return r;
   endfunction

   // Append one expected result behind the others
   task automatic queue_result(rsp_type r);
      pending_results = {pending_results, r};
   endtask

   // Advance the raster model by one accepted pixel, queue its results
   task automatic predict_pixel(req_type px);
      int unsigned w, h, x, y;
      bit fg, last_row, edge_pt, cont;
      logic [7:0] dep;
      w = eff_size(width_reg);
      h = eff_size(height_reg);
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      x = col_pos;
      y = row_pos;
      last_row = (y == h - 1);
      fg = (px.alpha > alpha_limit);
      dep = fg ? pseudo_depth(px, x, y, w, h) : 8'd0;
      if (y >= 1) begin
         edge_pt = (x == 0 || x == w - 1 || y == 1);
         cont = edge_pt;
         if (!edge_pt)
            cont = !fg_line_two[x] || !fg_line_two[x-1] || !fg_line_prev[x+1] || !fg;
         queue_result(make_result(x, y - 1, depth_line[x],
                                  fg_line_prev[x], cont, !last_row, 1'b0));
      end
      if (last_row)
         queue_result(make_result(x, y, dep, fg, 1'b1, 1'b1, x == w - 1));
      fg_line_two[x] = fg_line_prev[x];
      fg_line_prev[x] = fg;
      depth_line[x] = dep;
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Result checker
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && result_ch.valid && result_ch.ready) begin
         got = result_ch.data;
         if (pending_results.size() == 0) begin
            report_mismatch("queued results", 0, 1);
         end else begin
            want = pending_results.pop_front();
            if (got.col !== want.col)
               report_mismatch("col", int'(got.col), int'(want.col));
            if (got.row !== want.row)
               report_mismatch("row", int'(got.row), int'(want.row));
            if (got.depth !== want.depth)
               report_mismatch("depth", int'(got.depth), int'(want.depth));
            if (got.foreground !== want.foreground)
               report_mismatch("foreground", int'(got.foreground), int'(want.foreground));
            if (got.contour !== want.contour)
               report_mismatch("contour", int'(got.contour), int'(want.contour));
            if (got.end_of_run !== want.end_of_run)
               report_mismatch("end_of_run", int'(got.end_of_run), int'(want.end_of_run));
            if (got.end_of_frame !== want.end_of_frame)
               report_mismatch("end_of_frame", int'(got.end_of_frame),
                               int'(want.end_of_frame));
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Output stall pattern
   initial begin
      int stall;
      result_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = sink_idle_on ? $urandom_range(0, 18) : 0;
         if (stall > 0) begin
            result_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         result_ch.ready <= 1'b1;
         do @(posedge clock); while (!result_ch.valid);
      end
   end

   // Setup and access phases, then the bus returns to idle
   task automatic write_reg(logic [CSR_AW-1:0] addr, int unsigned value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (addr)
         ADDR_THRESHOLD: alpha_limit = value & 8'hFF;
         ADDR_WIDTH:     width_reg = value & 11'h7FF;
         ADDR_HEIGHT:    height_reg = value & 11'h7FF;
         default: ;
      endcase
   endtask

   // Let the block finish its frame before touching registers
   task automatic drain_block();
      pixel_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic setup_frame(int unsigned thr, int unsigned w, int unsigned h);
      drain_block();
      write_reg(ADDR_THRESHOLD, thr);
      write_reg(ADDR_WIDTH, w);
      write_reg(ADDR_HEIGHT, h);
   endtask

   task automatic send_pixel(req_type px);
      int gap;
      gap = src_idle_on ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         pixel_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pixel_ch.valid <= 1'b1;
      pixel_ch.data <= px;
      do @(posedge clock); while (!pixel_ch.ready);
      predict_pixel(px);
      pixels_sent++;
   endtask

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // One whole frame; blob mode draws an ellipse silhouette with some noise
   task automatic send_frame(bit blob);
      int unsigned w, h, x, y;
      int cx, cy, rx, ry, dx, dy;
      req_type px;
      w = eff_size(width_reg);
      h = eff_size(height_reg);
      cx = $urandom_range(0, w - 1);
      cy = $urandom_range(0, h - 1);
      rx = $urandom_range(1, w);
      ry = $urandom_range(1, h);
      src_idle_on = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      for (y = 0; y < h; y++) begin
         for (x = 0; x < w; x++) begin
            px.red = rand_chan();
            px.green = rand_chan();
            px.blue = rand_chan();
            px.alpha = rand_chan();
            if (blob && $urandom_range(0, 9) != 0) begin
               dx = int'(x) - cx;
               dy = int'(y) - cy;
               if (dx * dx * ry * ry + dy * dy * rx * rx <= rx * rx * ry * ry)
                  px.alpha = 8'($urandom_range(alpha_limit < 255 ? alpha_limit + 1 : 255,
                                               255));
               else
                  px.alpha = 8'($urandom_range(0, alpha_limit));
            end
            send_pixel(px);
         end
      end
   endtask

   task automatic test_single_pixel();
      req_type px;
      // zero size registers act as one
      setup_frame(0, 0, 0);
      px = '{8'h00, 8'h00, 8'h00, 8'h00};
      send_pixel(px);
      px = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_pixel(px);
      px = '{8'hFF, 8'h00, 8'hFF, 8'h01};
      send_pixel(px);
      setup_frame(128, 1, 1);
      px = '{8'h00, 8'hFF, 8'h00, 8'd128};
      send_pixel(px);
      px = '{8'hFF, 8'hFF, 8'hFF, 8'd129};
      send_pixel(px);
   endtask

   task automatic test_threshold_extremes();
      setup_frame(255, 3, 3);
      send_frame(1'b0);
      setup_frame(0, 4, 3);
      send_frame(1'b1);
   endtask

   task automatic test_small_shapes();
      req_type px;
      int unsigned x, y;
      // ring of foreground around one hole in a 5x5 frame
      setup_frame(100, 5, 5);
      for (y = 0; y < 5; y++)
         for (x = 0; x < 5; x++) begin
            px.red = 8'hFF; px.green = 8'hFF; px.blue = 8'hFF;
            px.alpha = (x == 2 && y == 2) ? 8'd0 : 8'd255;
            send_pixel(px);
         end
   endtask

   // Oversized registers saturate to the maximum; a partial frame is left
   // behind and a one-pixel frame restarts the raster counters
   task automatic test_largest_sizes();
      req_type px;
      int i;
      setup_frame(60, 2047, 1);
      for (i = 0; i < 60; i++) begin
         px = '{rand_chan(), rand_chan(), rand_chan(), rand_chan()};
         send_pixel(px);
      end
      setup_frame(60, 1, 1);
      send_pixel(px);
      setup_frame(60, 1, 2047);
      for (i = 0; i < 60; i++) begin
         px = '{rand_chan(), rand_chan(), rand_chan(), rand_chan()};
         send_pixel(px);
      end
      setup_frame(60, 1, 1);
      send_pixel(px);
   endtask

   task automatic test_random_frames();
      int goal;
      goal = pixels_sent + 480;
      while (pixels_sent < goal) begin
         setup_frame($urandom_range(0, 255), $urandom_range(1, 12), $urandom_range(1, 8));
         send_frame($urandom_range(0, 4) != 0);
      end
      drain_block();
   endtask

   initial begin
      reset <= 1'b1;
      pixel_ch.valid <= 1'b0;
      pixel_ch.data <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_pixel();
      test_threshold_extremes();
      test_small_shapes();
      test_largest_sizes();
      test_random_frames();
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
